// ===== sv/assert_macros.svh =====
// Assertion macros for the ordered operation id table.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OOIT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define OOIT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define OOIT_ASSERT(lbl, clk, rst_n, prop)
`define OOIT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== sv/ooit_pkg.sv =====
// Package for the ordered operation id table: field widths, codes, FSM states,
// and the command/status structs between controller and datapath. No dependencies.
package ooit_pkg;

    localparam int ACTION_W        = 2;
    localparam int KIND_W          = 2;
    localparam int OP_ID_W         = 64;
    localparam int COUNT_W         = 6;
    localparam int STATUS_W        = 2;
    localparam int TABLE_DEPTH_DEF = 32;
    localparam int ID_BITS_DEF     = 64;

    localparam logic KIND_NET = 1'b0;
    localparam logic KIND_STO = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD  = 2'd0,
        ACT_DEL  = 2'd1,
        ACT_QRY  = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_KIND = 2'd1,
        STAT_FULL     = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ADD_RESP,
        S_DEL_ACK,
        S_DEL_RD,
        S_DEL_CHK,
        S_SH_RD,
        S_SH_WR,
        S_Q_RD,
        S_Q_CHK,
        S_Q_FLUSH
    } t_state;

    typedef struct packed {
        logic req_load;
        logic idx_clr;
        logic idx_inc;
        logic rd_en;
        logic rd_next;
        logic add_exec;
        logic ack_out;
        logic shift_wr;
        logic dec_total;
        logic pend_push;
        logic pend_flush;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    kind_bad;
        logic    cnt_zero;
        logic    tbl_empty;
        logic    idx_last;
        logic    shift_done;
        logic    match_del;
        logic    match_kind;
        logic    cnt_done;
        logic    pend_valid;
        logic    out_free;
    } t_sts;

endpackage

// ===== sv/ooit_ifs.sv =====
// Request and response channel interfaces of the ordered operation id table.
// Depends on ooit_pkg for field widths.
interface ooit_req_if import ooit_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [KIND_W-1:0]   op_kind;
    logic [OP_ID_W-1:0]  op_id;
    logic [COUNT_W-1:0]  max_count;

    modport source (output valid, action, op_kind, op_id, max_count, input ready);
    modport sink   (input valid, action, op_kind, op_id, max_count, output ready);
endinterface

interface ooit_rsp_if import ooit_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                id_valid;
    logic [OP_ID_W-1:0]  found_id;
    logic [COUNT_W-1:0]  found_count;
    logic                last;

    modport source (output valid, status, id_valid, found_id, found_count, last,
                    input ready);
    modport sink   (input valid, status, id_valid, found_id, found_count, last,
                    output ready);
endinterface

// ===== sv/ooit_ctrl.sv =====
// Controller FSM of the ordered operation id table: sequences add, delete walk,
// gap-closing shift and query walk. Depends on ooit_pkg.
module ooit_ctrl import ooit_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.action)
                    ACT_ADD: n_state = S_ADD_RESP;
                    ACT_DEL: n_state = i_sts.tbl_empty ? S_DEL_ACK : S_DEL_RD;
                    ACT_QRY: begin
                        if (i_sts.kind_bad || i_sts.cnt_zero || i_sts.tbl_empty) begin
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_Q_RD;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_ADD_RESP: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DEL_ACK: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DEL_RD: n_state = S_DEL_CHK;
            S_DEL_CHK: begin
                if (i_sts.match_del) begin
                    n_state = i_sts.idx_last ? S_DEL_ACK : S_SH_RD;
                end else begin
                    n_state = i_sts.idx_last ? S_DEL_ACK : S_DEL_RD;
                end
            end
            S_SH_RD: n_state = S_SH_WR;
            S_SH_WR: n_state = i_sts.shift_done ? S_DEL_ACK : S_SH_RD;
            S_Q_RD:  n_state = S_Q_CHK;
            S_Q_CHK: begin
                if (i_sts.match_kind) begin
                    if (!i_sts.pend_valid || i_sts.out_free) begin
                        if (i_sts.cnt_done || i_sts.idx_last) begin
                            n_state = S_Q_FLUSH;
                        end else begin
                            n_state = S_Q_RD;
                        end
                    end
                end else if (i_sts.idx_last) begin
                    n_state = i_sts.pend_valid ? S_Q_FLUSH : S_IDLE;
                end else begin
                    n_state = S_Q_RD;
                end
            end
            S_Q_FLUSH: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_ready        = 1'b1;
                o_cmd.req_load = i_valid;
            end
            S_DECODE: o_cmd.idx_clr = 1'b1;
            S_ADD_RESP: o_cmd.add_exec = i_sts.out_free;
            S_DEL_ACK:  o_cmd.ack_out  = i_sts.out_free;
            S_DEL_RD:   o_cmd.rd_en    = 1'b1;
            S_DEL_CHK: begin
                o_cmd.dec_total = i_sts.match_del && i_sts.idx_last;
                o_cmd.idx_inc   = !i_sts.match_del && !i_sts.idx_last;
            end
            S_SH_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_next = 1'b1;
            end
            S_SH_WR: begin
                o_cmd.shift_wr  = 1'b1;
                o_cmd.idx_inc   = 1'b1;
                o_cmd.dec_total = i_sts.shift_done;
            end
            S_Q_RD: o_cmd.rd_en = 1'b1;
            S_Q_CHK: begin
                if (i_sts.match_kind) begin
                    if (!i_sts.pend_valid || i_sts.out_free) begin
                        o_cmd.pend_push = 1'b1;
                        o_cmd.idx_inc   = !i_sts.cnt_done && !i_sts.idx_last;
                    end
                end else begin
                    o_cmd.idx_inc = !i_sts.idx_last;
                end
            end
            S_Q_FLUSH: o_cmd.pend_flush = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== sv/ooit_dp.sv =====
// Datapath of the ordered operation id table: request latch, entry memory,
// walk index, pending query result and response register. Depends on ooit_pkg.
`include "assert_macros.svh"
module ooit_dp import ooit_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ooit_req_if.sink        i_req,
    ooit_rsp_if.source      o_rsp,
    input  t_cmd            i_cmd,
    output t_sts            o_sts
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W = ID_BITS + 1;

    t_action              r_action;
    logic [KIND_W-1:0]    r_kind;
    logic [ID_BITS-1:0]   r_id;
    logic [COUNT_W-1:0]   r_max;

    logic [ENT_W-1:0]     r_mem [TABLE_DEPTH];
    logic [ENT_W-1:0]     r_rd_data;
    logic [CNT_W-1:0]     r_total;
    logic [CNT_W-1:0]     n_total;
    logic [IDX_W-1:0]     r_idx;

    logic                 r_pend_valid;
    logic [ID_BITS-1:0]   r_pend_id;
    logic [COUNT_W-1:0]   r_found_cnt;

    logic                 r_out_valid;
    t_status              r_out_status;
    logic                 r_out_id_valid;
    logic [OP_ID_W-1:0]   r_out_id;
    logic [COUNT_W-1:0]   r_out_cnt;
    logic                 r_out_last;

    t_status              n_out_status;
    logic                 n_out_id_valid;
    logic [OP_ID_W-1:0]   n_out_id;
    logic [COUNT_W-1:0]   n_out_cnt;
    logic                 n_out_last;

    logic                 w_kind_bad;
    logic                 w_full;
    logic                 w_add_ok;
    logic                 w_match_kind;
    logic                 w_match_del;
    logic                 w_out_free;
    logic                 w_out_load;
    logic                 w_pend_emit;
    logic [IDX_W-1:0]     w_rd_addr;
    logic                 w_wr_en;
    logic [IDX_W-1:0]     w_wr_addr;
    logic [ENT_W-1:0]     w_wr_data;

    assign w_kind_bad   = r_kind[1];
    assign w_full       = (r_total == CNT_W'(TABLE_DEPTH));
    assign w_add_ok     = !w_kind_bad && !w_full;
    assign w_match_kind = !r_kind[1] && (r_rd_data[ID_BITS] == r_kind[0]);
    assign w_match_del  = w_match_kind && (r_rd_data[ID_BITS-1:0] == r_id);
    assign w_out_free   = !r_out_valid || o_rsp.ready;
    assign w_pend_emit  = i_cmd.pend_push && r_pend_valid;
    assign w_out_load   = i_cmd.add_exec || i_cmd.ack_out || w_pend_emit
                        || i_cmd.pend_flush;

    always_comb begin
        o_sts.action     = r_action;
        o_sts.kind_bad   = w_kind_bad;
        o_sts.cnt_zero   = (r_max == '0);
        o_sts.tbl_empty  = (r_total == '0);
        o_sts.idx_last   = (CNT_W'(r_idx) + CNT_W'(1) == r_total);
        o_sts.shift_done = (CNT_W'(r_idx) + CNT_W'(2) == r_total);
        o_sts.match_del  = w_match_del;
        o_sts.match_kind = w_match_kind;
        o_sts.cnt_done   = (r_found_cnt + COUNT_W'(1) == r_max);
        o_sts.pend_valid = r_pend_valid;
        o_sts.out_free   = w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_action <= t_action'(i_req.action);
            r_kind   <= i_req.op_kind;
            r_id     <= i_req.op_id[ID_BITS-1:0];
            r_max    <= i_req.max_count;
        end
    end

    assign w_rd_addr = i_cmd.rd_next ? r_idx + IDX_W'(1) : r_idx;
    assign w_wr_en   = (i_cmd.add_exec && w_add_ok) || i_cmd.shift_wr;
    assign w_wr_addr = i_cmd.shift_wr ? r_idx : r_total[IDX_W-1:0];
    assign w_wr_data = i_cmd.shift_wr ? r_rd_data : {r_kind[0], r_id};

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_comb begin
        n_total = r_total;
        if (i_cmd.add_exec && w_add_ok) begin
            n_total = r_total + CNT_W'(1);
        end else if (i_cmd.dec_total) begin
            n_total = r_total - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else begin
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.req_load || i_cmd.pend_flush) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.pend_push) begin
            r_pend_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_found_cnt <= '0;
        end else if (i_cmd.pend_push) begin
            r_found_cnt <= r_found_cnt + COUNT_W'(1);
            r_pend_id   <= r_rd_data[ID_BITS-1:0];
        end
    end

    always_comb begin
        n_out_status   = STAT_OK;
        n_out_id_valid = 1'b0;
        n_out_id       = '0;
        n_out_cnt      = '0;
        n_out_last     = 1'b1;
        if (i_cmd.add_exec) begin
            if (w_kind_bad) begin
                n_out_status = STAT_BAD_KIND;
            end else if (w_full) begin
                n_out_status = STAT_FULL;
            end
        end else if (w_pend_emit || i_cmd.pend_flush) begin
            n_out_id_valid = 1'b1;
            n_out_id       = OP_ID_W'(r_pend_id);
            n_out_cnt      = r_found_cnt;
            n_out_last     = i_cmd.pend_flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_status   <= n_out_status;
            r_out_id_valid <= n_out_id_valid;
            r_out_id       <= n_out_id;
            r_out_cnt      <= n_out_cnt;
            r_out_last     <= n_out_last;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.id_valid    = r_out_id_valid;
    assign o_rsp.found_id    = r_out_id;
    assign o_rsp.found_count = r_out_cnt;
    assign o_rsp.last        = r_out_last;

    `OOIT_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (r_total == '0 && !r_out_valid))
    `OOIT_ASSERT(a_total_bound, i_clk, i_rst_n, r_total <= CNT_W'(TABLE_DEPTH))
    `OOIT_ASSERT(a_load_when_free, i_clk, i_rst_n, w_out_load |-> w_out_free)
    `OOIT_ASSERT(a_flush_has_pend, i_clk, i_rst_n, i_cmd.pend_flush |-> r_pend_valid)
    `OOIT_ASSERT(a_add_grows, i_clk, i_rst_n, (i_cmd.add_exec && w_add_ok) |=> (r_total == $past(r_total) + CNT_W'(1)))
    `OOIT_ASSERT(a_shift_in_range, i_clk, i_rst_n, i_cmd.shift_wr |-> (CNT_W'(r_idx) + CNT_W'(1) < r_total))

endmodule

// ===== sv/ordered_op_id_table.sv =====
// Ordered operation id table, top level.
// Request channel i_req (action, op_kind, op_id, max_count) and response
// channel o_rsp (status, id_valid, found_id, found_count, last), valid/ready.
// Add appends {kind, id} at the tail and answers with one response carrying
// ok, bad kind or full. Delete removes the first entry matching kind and id,
// moves later entries up and answers with one ok response. Query answers
// with one response per stored id of the requested kind, in table order, up
// to max_count, last set on the final one; an empty query answers nothing.
// One request at a time. Delete and query walk the table through one
// single-port-read memory, reading and then checking each entry visited.
// A new request is taken while the last response still waits in the output
// register; a stalled receiver holds the walk at the next response.
// Reset empties the table at once (entry count to zero) and drops any
// pending response; entry storage itself is not cleared.
// Depends on ooit_pkg, ooit_ifs, ooit_ctrl and ooit_dp.
module ordered_op_id_table import ooit_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ooit_req_if.sink    i_req,
    ooit_rsp_if.source  o_rsp
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_ready;

    assign i_req.ready = w_ready;

    ooit_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (w_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    ooit_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );

endmodule
